### hdl/dmp_pkg.sv
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types, codes and helpers of the DNS message parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dmp_pkg;

    typedef enum logic [2:0] {
        SEC_PREFIX     = 3'd0,
        SEC_HEADER     = 3'd1,
        SEC_QUESTION   = 3'd2,
        SEC_ANSWER     = 3'd3,
        SEC_AUTHORITY  = 3'd4,
        SEC_ADDITIONAL = 3'd5,
        SEC_SURPLUS    = 3'd6
    } section_t;

    typedef enum logic [3:0] {
        ROLE_PREFIX    = 4'd0,
        ROLE_HEADER    = 4'd1,
        ROLE_LABEL_LEN = 4'd2,
        ROLE_NAME_CHAR = 4'd3,
        ROLE_NAME_END  = 4'd4,
        ROLE_POINTER   = 4'd5,
        ROLE_TYPE      = 4'd6,
        ROLE_CLASS     = 4'd7,
        ROLE_TTL       = 4'd8,
        ROLE_RDLENGTH  = 4'd9,
        ROLE_RDATA     = 4'd10,
        ROLE_SURPLUS   = 4'd11
    } role_t;

    typedef enum logic [1:0] {
        ERR_NONE           = 2'd0,
        ERR_TRUNCATED      = 2'd1,
        ERR_RESERVED_LABEL = 2'd2
    } err_t;

    typedef logic [3:0][15:0] counts_t;

    typedef struct packed {
        section_t    section;
        role_t       role;
        logic [7:0]  echo_byte;
        logic [15:0] record_index;
        logic        field_done;
        logic [31:0] field_value;
        logic        packet_end;
        err_t        error_code;
    } result_t;

    localparam logic [15:0] HDR_FIRST_COUNT = 16'd5;
    localparam logic [15:0] HDR_LAST_BYTE   = 16'd11;
    localparam logic [2:0]  SHORT_FIELD_LEN = 3'd2;
    localparam logic [2:0]  TTL_FIELD_LEN   = 3'd4;

    // Skips sections whose count is zero; lands on surplus past the last one.
    function automatic section_t next_populated(input logic [2:0] start,
                                                input counts_t counts);
        logic [2:0] s;
        logic [1:0] idx;
        s = start;
        for (int i = 0; i < 4; i++)
        begin
            idx = 2'(s - 3'd2);
            if (s < 3'(SEC_SURPLUS) && counts[idx] == 16'd0)
            begin
                s = s + 3'd1;
            end
        end
        return section_t'(s);
    endfunction

endpackage

`default_nettype wire

### hdl/dmp_if.sv
// ----------------------------------------------------------------------------
// dmp_if
// Valid/ready channels for stream bytes and parse results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface dmp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  section;
    logic [3:0]  role;
    logic [7:0]  echo_byte;
    logic [15:0] record_index;
    logic        field_done;
    logic [31:0] field_value;
    logic        packet_end;
    logic [1:0]  error_code;

    modport source (output valid, output section, output role, output echo_byte,
                    output record_index, output field_done, output field_value,
                    output packet_end, output error_code, input ready);
    modport sink   (input valid, input section, input role, input echo_byte,
                    input record_index, input field_done, input field_value,
                    input packet_end, input error_code, output ready);
endinterface

`default_nettype wire

### hdl/dmp_in_reg.sv
// ----------------------------------------------------------------------------
// dmp_in_reg
// Input register holding one stream byte ahead of the parse logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_in_reg (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dmp_byte_if.sink    byte_chan,
    input  wire logic   advance,
    output logic        byte_valid,
    output logic [7:0]  byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       take;

    assign byte_chan.ready = !valid_reg || advance;
    assign take            = byte_chan.valid && byte_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= byte_chan.stream_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

`default_nettype wire

### hdl/dmp_parse_core.sv
// ----------------------------------------------------------------------------
// dmp_parse_core
// Parser state and the per-byte update that classifies each byte and
// assembles big-endian fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_parse_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  in_byte,
    output dmp_pkg::result_t result
);
    import dmp_pkg::*;

    logic [15:0] plen_reg,   plen_next;
    logic [15:0] bs_reg,     bs_next;
    section_t    sec_reg,    sec_next;
    role_t       role_reg,   role_next;
    counts_t     counts_reg, counts_next;
    logic [15:0] rec_reg,    rec_next;
    logic [31:0] acc_reg,    acc_next;
    logic [2:0]  fbl_reg,    fbl_next;
    logic [5:0]  lbl_reg,    lbl_next;
    logic [15:0] rdl_reg,    rdl_next;
    err_t        sticky_reg, sticky_next;

    logic [15:0] hdr_word;
    logic [31:0] fix_word;
    logic [5:0]  lbl_dec;
    logic [15:0] rdl_dec;
    logic [2:0]  fbl_dec;
    logic [15:0] rec_inc;
    logic [15:0] bs_inc;
    logic [1:0]  hdr_idx;
    logic [15:0] count_sel;
    logic        in_records;

    logic        do_finish;
    logic        do_enter;
    logic [2:0]  enter_from;
    section_t    out_sec;
    role_t       out_role;
    logic [15:0] out_index;
    logic        out_done;
    logic [31:0] out_value;
    logic        out_pend;

    assign hdr_word   = {acc_reg[7:0], in_byte};
    assign fix_word   = {acc_reg[23:0], in_byte};
    assign lbl_dec    = lbl_reg - 6'd1;
    assign rdl_dec    = rdl_reg - 16'd1;
    assign fbl_dec    = fbl_reg - 3'd1;
    assign rec_inc    = rec_reg + 16'd1;
    assign bs_inc     = bs_reg + 16'd1;
    assign hdr_idx    = 2'((bs_reg - HDR_FIRST_COUNT) >> 1);
    assign count_sel  = counts_reg[2'(3'(sec_reg) - 3'd2)];
    assign in_records = (sec_reg >= SEC_QUESTION) && (sec_reg <= SEC_ADDITIONAL);

    always_comb
    begin
        plen_next   = plen_reg;
        bs_next     = bs_reg;
        sec_next    = sec_reg;
        role_next   = role_reg;
        counts_next = counts_reg;
        rec_next    = rec_reg;
        acc_next    = acc_reg;
        fbl_next    = fbl_reg;
        lbl_next    = lbl_reg;
        rdl_next    = rdl_reg;
        sticky_next = sticky_reg;
        do_finish   = 1'b0;
        do_enter    = 1'b0;
        enter_from  = 3'(SEC_QUESTION);
        out_sec     = sec_reg;
        out_role    = role_reg;
        out_index   = 16'd0;
        out_done    = 1'b0;
        out_value   = 32'd0;
        out_pend    = 1'b0;

        if (sec_reg == SEC_PREFIX)
        begin
            out_role = ROLE_PREFIX;
            if (bs_reg == 16'd0)
            begin
                sticky_next = ERR_NONE;
                acc_next    = {24'd0, in_byte};
                bs_next     = 16'd1;
            end
            else
            begin
                plen_next   = hdr_word;
                out_done    = 1'b1;
                out_value   = {16'd0, hdr_word};
                bs_next     = 16'd0;
                counts_next = '0;
                rec_next    = 16'd0;
                acc_next    = 32'd0;
                fbl_next    = 3'd0;
                lbl_next    = 6'd0;
                rdl_next    = 16'd0;
                sec_next    = SEC_HEADER;
                role_next   = ROLE_HEADER;
                if (hdr_word == 16'd0)
                begin
                    out_pend  = 1'b1;
                    if (sticky_reg == ERR_NONE)
                    begin
                        sticky_next = ERR_TRUNCATED;
                    end
                    sec_next  = SEC_PREFIX;
                    role_next = ROLE_PREFIX;
                end
            end
        end
        else
        begin
            if (in_records)
            begin
                out_index = rec_reg;
            end

            if (sec_reg == SEC_HEADER)
            begin
                out_role = ROLE_HEADER;
                acc_next = {16'd0, hdr_word};
                if (bs_reg[0])
                begin
                    out_done  = 1'b1;
                    out_value = {16'd0, hdr_word};
                    if (bs_reg >= HDR_FIRST_COUNT && bs_reg <= HDR_LAST_BYTE)
                    begin
                        counts_next[hdr_idx] = hdr_word;
                    end
                    acc_next = 32'd0;
                    if (bs_reg >= HDR_LAST_BYTE)
                    begin
                        do_enter   = 1'b1;
                        enter_from = 3'(SEC_QUESTION);
                    end
                end
            end
            else if (sec_reg == SEC_SURPLUS || role_reg > ROLE_RDATA
                     || role_reg < ROLE_LABEL_LEN || role_reg == ROLE_NAME_END)
            begin
                out_sec   = SEC_SURPLUS;
                out_role  = ROLE_SURPLUS;
                out_index = 16'd0;
                sec_next  = SEC_SURPLUS;
                role_next = ROLE_SURPLUS;
            end
            else
            begin
                unique case (role_reg) inside
                    ROLE_LABEL_LEN:
                    begin
                        if (in_byte[7:6] == 2'b00)
                        begin
                            if (in_byte == 8'd0)
                            begin
                                out_role  = ROLE_NAME_END;
                                role_next = ROLE_TYPE;
                                fbl_next  = SHORT_FIELD_LEN;
                                acc_next  = 32'd0;
                            end
                            else
                            begin
                                lbl_next  = in_byte[5:0];
                                role_next = ROLE_NAME_CHAR;
                            end
                        end
                        else if (in_byte[7:6] == 2'b11)
                        begin
                            out_role  = ROLE_POINTER;
                            acc_next  = {26'd0, in_byte[5:0]};
                            role_next = ROLE_POINTER;
                        end
                        else
                        begin
                            sticky_next = ERR_RESERVED_LABEL;
                            sec_next    = SEC_SURPLUS;
                            role_next   = ROLE_SURPLUS;
                        end
                    end
                    ROLE_NAME_CHAR:
                    begin
                        lbl_next = lbl_dec;
                        if (lbl_dec == 6'd0)
                        begin
                            role_next = ROLE_LABEL_LEN;
                        end
                    end
                    ROLE_POINTER:
                    begin
                        out_done  = 1'b1;
                        out_value = {18'd0, acc_reg[5:0], in_byte};
                        role_next = ROLE_TYPE;
                        fbl_next  = SHORT_FIELD_LEN;
                        acc_next  = 32'd0;
                    end
                    ROLE_RDATA:
                    begin
                        rdl_next = rdl_dec;
                        if (rdl_dec == 16'd0)
                        begin
                            do_finish = 1'b1;
                        end
                    end
                    ROLE_TYPE, ROLE_CLASS, ROLE_TTL, ROLE_RDLENGTH:
                    begin
                        acc_next = fix_word;
                        fbl_next = fbl_dec;
                        if (fbl_dec == 3'd0)
                        begin
                            out_done  = 1'b1;
                            out_value = fix_word;
                            unique case (role_reg)
                                ROLE_TYPE:
                                begin
                                    role_next = ROLE_CLASS;
                                    fbl_next  = SHORT_FIELD_LEN;
                                    acc_next  = 32'd0;
                                end
                                ROLE_CLASS:
                                begin
                                    if (sec_reg == SEC_QUESTION)
                                    begin
                                        do_finish = 1'b1;
                                    end
                                    else
                                    begin
                                        role_next = ROLE_TTL;
                                        fbl_next  = TTL_FIELD_LEN;
                                        acc_next  = 32'd0;
                                    end
                                end
                                ROLE_TTL:
                                begin
                                    role_next = ROLE_RDLENGTH;
                                    fbl_next  = SHORT_FIELD_LEN;
                                    acc_next  = 32'd0;
                                end
                                default:
                                begin
                                    rdl_next = fix_word[15:0];
                                    acc_next = 32'd0;
                                    if (fix_word[15:0] == 16'd0)
                                    begin
                                        do_finish = 1'b1;
                                    end
                                    else
                                    begin
                                        role_next = ROLE_RDATA;
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        role_next = role_reg;
                    end
                endcase
            end

            if (do_finish)
            begin
                rec_next = rec_inc;
                if (rec_inc >= count_sel)
                begin
                    do_enter   = 1'b1;
                    enter_from = 3'(sec_reg) + 3'd1;
                end
                else
                begin
                    role_next = ROLE_LABEL_LEN;
                end
            end

            if (do_enter)
            begin
                sec_next  = next_populated(enter_from, counts_next);
                rec_next  = 16'd0;
                role_next = (sec_next < SEC_SURPLUS) ? ROLE_LABEL_LEN : ROLE_SURPLUS;
            end

            bs_next = bs_inc;
            if (bs_inc >= plen_reg)
            begin
                out_pend = 1'b1;
                if (sec_next != SEC_SURPLUS && sticky_next == ERR_NONE)
                begin
                    sticky_next = ERR_TRUNCATED;
                end
                bs_next     = 16'd0;
                sec_next    = SEC_PREFIX;
                role_next   = ROLE_PREFIX;
                counts_next = '0;
                rec_next    = 16'd0;
                acc_next    = 32'd0;
                fbl_next    = 3'd0;
                lbl_next    = 6'd0;
                rdl_next    = 16'd0;
            end
        end
    end

    always_comb
    begin
        result.section      = out_sec;
        result.role         = out_role;
        result.echo_byte    = in_byte;
        result.record_index = out_index;
        result.field_done   = out_done;
        result.field_value  = out_value;
        result.packet_end   = out_pend;
        result.error_code   = sticky_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg   <= 16'd0;
            bs_reg     <= 16'd0;
            sec_reg    <= SEC_PREFIX;
            role_reg   <= ROLE_PREFIX;
            counts_reg <= '0;
            rec_reg    <= 16'd0;
            acc_reg    <= 32'd0;
            fbl_reg    <= 3'd0;
            lbl_reg    <= 6'd0;
            rdl_reg    <= 16'd0;
            sticky_reg <= ERR_NONE;
        end
        else if (fire)
        begin
            plen_reg   <= plen_next;
            bs_reg     <= bs_next;
            sec_reg    <= sec_next;
            role_reg   <= role_next;
            counts_reg <= counts_next;
            rec_reg    <= rec_next;
            acc_reg    <= acc_next;
            fbl_reg    <= fbl_next;
            lbl_reg    <= lbl_next;
            rdl_reg    <= rdl_next;
            sticky_reg <= sticky_next;
        end
    end

endmodule

`default_nettype wire

### hdl/dmp_out_reg.sv
// ----------------------------------------------------------------------------
// dmp_out_reg
// Result register driving the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire dmp_pkg::result_t  result,
    output logic                   advance,
    dmp_result_if.source           result_chan
);
    import dmp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign advance = !valid_reg || result_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (result_chan.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign result_chan.valid        = valid_reg;
    assign result_chan.section      = res_reg.section;
    assign result_chan.role         = res_reg.role;
    assign result_chan.echo_byte    = res_reg.echo_byte;
    assign result_chan.record_index = res_reg.record_index;
    assign result_chan.field_done   = res_reg.field_done;
    assign result_chan.field_value  = res_reg.field_value;
    assign result_chan.packet_end   = res_reg.packet_end;
    assign result_chan.error_code   = res_reg.error_code;

endmodule

`default_nettype wire

### hdl/dns_message_parser_core.sv
// An accepted byte goes to the input register; its result then goes to the result register.
// Throughput: one byte per cycle unless the result stalls; parser state updates on each byte.
// A stalled result holds in the result register while the input register takes one more byte.
// Reset clears the parser state and both valid flags; the first two bytes are a length prefix.
// ----------------------------------------------------------------------------
// dns_message_parser_core
// Parses a length-prefixed DNS stream one byte at a time and tags each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_message_parser_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dmp_byte_if.sink     byte_chan,
    dmp_result_if.source result_chan
);
    import dmp_pkg::*;

    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       fire;
    result_t    result;

    assign fire = byte_valid && advance;

    dmp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    dmp_parse_core u_parse_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (byte_data),
        .result  (result)
    );

    dmp_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .result      (result),
        .advance     (advance),
        .result_chan (result_chan)
    );

endmodule

`default_nettype wire

### hdl/dmp_checker.sv
// ----------------------------------------------------------------------------
// dmp_checker
// Port-level checks of the parser results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  section,
    input wire logic [3:0]  role,
    input wire logic [15:0] record_index,
    input wire logic        field_done,
    input wire logic [31:0] field_value,
    input wire logic        packet_end,
    input wire logic [1:0]  error_code
);
    import dmp_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(section) && $stable(role)
            && $stable(field_value) && $stable(packet_end) && $stable(error_code))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !field_done |-> field_value == 32'd0)
        else $error("field value without a completed field");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && section == 3'(SEC_SURPLUS)
            |-> role == 4'(ROLE_SURPLUS) && record_index == 16'd0)
        else $error("surplus byte with wrong role or index");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (section == 3'(SEC_PREFIX) || section == 3'(SEC_HEADER))
            |-> record_index == 16'd0 && role[3:1] == 3'd0 && role[0] == section[0])
        else $error("prefix or header byte with wrong role or index");

endmodule

bind dns_message_parser_core dmp_checker u_dmp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_chan.valid),
    .out_ready    (result_chan.ready),
    .section      (result_chan.section),
    .role         (result_chan.role),
    .record_index (result_chan.record_index),
    .field_done   (result_chan.field_done),
    .field_value  (result_chan.field_value),
    .packet_end   (result_chan.packet_end),
    .error_code   (result_chan.error_code)
);

`default_nettype wire
